/* hw/rtl/ihg_pkg.sv */
// Package with shared types, constants and the header byte selection for the IPv4 header generator.
`default_nettype none
package ihg_pkg;

  // Fixed header layout.
  localparam int unsigned HdrBytes   = 20;
  localparam int unsigned IdxW       = 5;
  localparam logic [7:0]  VerIhl     = 8'h45;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HdrBytes - 1);

  // Partial and full checksum sum widths (four and seven 16-bit words).
  localparam int unsigned PsumW = 18;
  localparam int unsigned SumW  = 19;

  // Configuration register map.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] RegLocalAddress = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTimeToLive   = 1'b1;
  localparam logic [31:0] LocalAddressReset = 32'h0000_0000;
  localparam logic [7:0]  TimeToLiveReset   = 8'd64;

  // Default depth of the request queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Send request as it arrives on the input channel.
  typedef struct packed {
    logic [31:0] dst_address;
    logic [7:0]  protocol;
    logic [15:0] payload_length;
  } in_item_t;

  // One header byte on the result channel.
  typedef struct packed {
    logic [7:0]      header_byte;
    logic [IdxW-1:0] byte_index;
    logic            last_byte;
  } out_item_t;

  // Fully classified header record passed from front to back.
  typedef struct packed {
    logic [15:0] total_length;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [15:0] checksum;
    logic [31:0] src_address;
    logic [31:0] dst_address;
  } hdr_rec_t;

  // Select one header byte in network byte order.
  function automatic logic [7:0] hdr_byte(input hdr_rec_t rec, input logic [IdxW-1:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = VerIhl;
      5'd2:    b = rec.total_length[15:8];
      5'd3:    b = rec.total_length[7:0];
      5'd8:    b = rec.ttl;
      5'd9:    b = rec.protocol;
      5'd10:   b = rec.checksum[15:8];
      5'd11:   b = rec.checksum[7:0];
      5'd12:   b = rec.src_address[31:24];
      5'd13:   b = rec.src_address[23:16];
      5'd14:   b = rec.src_address[15:8];
      5'd15:   b = rec.src_address[7:0];
      5'd16:   b = rec.dst_address[31:24];
      5'd17:   b = rec.dst_address[23:16];
      5'd18:   b = rec.dst_address[15:8];
      5'd19:   b = rec.dst_address[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ihg_front.sv */
// Front end: accepts send requests, forms the total length and the header checksum.
`default_nettype none
module ihg_front
  import ihg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_push,
  input  wire in_item_t in_data,
  output logic          in_full,
  input  wire logic [31:0] src_address,
  input  wire logic [7:0]  ttl,
  output logic          q_push,
  output hdr_rec_t      q_wdata,
  input  wire logic     q_full
);

  logic              s1_valid_r, s1_valid_nxt;
  logic [31:0]       dst_r;
  logic [31:0]       src_r;
  logic [7:0]        ttl_r;
  logic [7:0]        proto_r;
  logic [15:0]       total_r;
  logic [PsumW-1:0]  psum_r;
  logic              accept;
  logic [SumW-1:0]   sum;
  logic [16:0]       fold1;
  logic [15:0]       fold2;

  // The stage takes a new request when it is empty or hands its record on.
  assign q_push  = s1_valid_r && !q_full;
  assign in_full = s1_valid_r && q_full;
  assign accept  = in_push && !in_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Capture the request with total length and the sum of the fixed words.
  always_ff @(posedge clk) begin
    if (accept) begin
      dst_r   <= in_data.dst_address;
      src_r   <= src_address;
      ttl_r   <= ttl;
      proto_r <= in_data.protocol;
      total_r <= in_data.payload_length + 16'(HdrBytes);
      psum_r  <= PsumW'({VerIhl, 8'h00}) + PsumW'({ttl, in_data.protocol})
               + PsumW'(src_address[31:16]) + PsumW'(src_address[15:0]);
    end
  end

  // Finish the ones' complement sum with end-around carries.
  always_comb begin
    sum   = SumW'(psum_r) + SumW'(total_r) + SumW'(dst_r[31:16]) + SumW'(dst_r[15:0]);
    fold1 = 17'(sum[15:0]) + 17'(sum[SumW-1:16]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
  end

  always_comb begin
    q_wdata.total_length = total_r;
    q_wdata.ttl          = ttl_r;
    q_wdata.protocol     = proto_r;
    q_wdata.checksum     = ~fold2;
    q_wdata.src_address  = src_r;
    q_wdata.dst_address  = dst_r;
  end

endmodule
`default_nettype wire

/* hw/rtl/ihg_queue.sv */
// Small first-in first-out queue of header records between front and back.
`default_nettype none
module ihg_queue
  import ihg_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire hdr_rec_t wdata,
  output logic          full,
  input  wire logic     pop,
  output hdr_rec_t      rdata,
  output logic          valid
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  hdr_rec_t            mem_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]     count_r, count_nxt;
  logic                do_push, do_pop;

  assign full    = (count_r == CntW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // Pointer and fill count update, pointers wrap at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ihg_back.sv */
// Back end: serializes each header record into twenty bytes through an output register.
`default_nettype none
module ihg_back
  import ihg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire hdr_rec_t q_rdata,
  output logic          q_pop,
  output logic          out_empty,
  input  wire logic     out_pop,
  output out_item_t     out_data
);

  hdr_rec_t         cur_r;
  logic             cur_valid_r, cur_valid_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r;
  logic             out_take, out_free, emit, done;

  assign out_take  = out_valid_r && out_pop;
  assign out_free  = !out_valid_r || out_take;
  assign emit      = cur_valid_r && out_free;
  assign done      = emit && (idx_r == LastIdx);
  assign q_pop     = q_valid && (!cur_valid_r || done);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // Record, byte counter and output register control.
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (emit) begin
      out_r.header_byte <= hdr_byte(cur_r, idx_r);
      out_r.byte_index  <= idx_r;
      out_r.last_byte   <= (idx_r == LastIdx);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ipv4_header_generator_core.sv */
// Top level of the IPv4 header generator: configuration registers, front, queue and back.
//
// Each accepted send request produces the 20-byte IPv4 header, one byte per result
// transaction, in network byte order with the last byte flagged. Results stream at one
// byte per cycle while pop is held; a request occupies the byte serializer in the back
// end until its last byte is emitted. The front end computes the total length and the
// checksum in two steps and parks the finished record in a small queue, so new requests
// are taken while earlier headers are still going out; a request passes through the
// front register, the queue, the current record register and the output register.
// The source address and TTL registers should only be written while no request is
// outstanding.
`default_nettype none
module ipv4_header_generator_core
  import ihg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  input  wire in_item_t            in_data,
  output logic                     in_full,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output out_item_t                out_data,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  logic [31:0] local_address_r, local_address_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic        q_push, q_full, q_pop, q_valid;
  hdr_rec_t    q_wdata, q_rdata;

  // Configuration register writes.
  always_comb begin
    local_address_nxt = local_address_r;
    ttl_nxt           = ttl_r;
    if (cfg_we) begin
      case (cfg_index)
        RegLocalAddress: local_address_nxt = cfg_data;
        RegTimeToLive:   ttl_nxt           = cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= LocalAddressReset;
      ttl_r           <= TimeToLiveReset;
    end else begin
      local_address_r <= local_address_nxt;
      ttl_r           <= ttl_nxt;
    end
  end

  ihg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data     (in_data),
    .in_full     (in_full),
    .src_address (local_address_r),
    .ttl         (ttl_r),
    .q_push      (q_push),
    .q_wdata     (q_wdata),
    .q_full      (q_full)
  );

  ihg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  ihg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/ihg_checker.sv */
// Port-level checker for the IPv4 header generator and its bind to the top level.
`default_nettype none
module ihg_checker
  import ihg_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_empty,
  input wire logic      out_pop,
  input wire out_item_t out_data
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // The last flag marks exactly the final header position.
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.last_byte == (out_data.byte_index == LastIdx)))
    else $error("last_byte does not match byte_index");

  // Every header opens with the version and header length byte.
  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.byte_index == '0) |-> (out_data.header_byte == VerIhl))
    else $error("first header byte is not version/IHL");

  // Within a header the bytes follow each other without a gap.
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_data.last_byte) |=>
      (!out_empty && out_data.byte_index == $past(out_data.byte_index) + 1'b1))
    else $error("header bytes not contiguous");

endmodule

bind ipv4_header_generator_core ihg_checker u_ihg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire
